// File: hdl/bpc_pkg.sv
// Button press classifier package: shared types, register indexes,
// reset values and the combination-to-code mapping.
// No dependencies.
package bpc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned MillisW = 11;
  localparam int unsigned SecsW   = 8;
  localparam int unsigned CodeW   = 3;

  localparam logic [MillisW-1:0] MS_PER_SEC = MillisW'(1000);

  localparam logic [CfgW-1:0] READ_PERIOD_RST   = 8'd50;
  localparam logic [CfgW-1:0] FIRST_LONG_RST    = 8'd20;
  localparam logic [CfgW-1:0] LONG_REPEAT_RST   = 8'd10;
  localparam logic [CfgW-1:0] ONE_TIME_SECS_RST = 8'd5;
  localparam logic [CfgW-1:0] RELEASE_CNT_RST   = 8'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_READ_PERIOD   = 3'd0,
    CFG_FIRST_LONG    = 3'd1,
    CFG_LONG_REPEAT   = 3'd2,
    CFG_ONE_TIME_SECS = 3'd3,
    CFG_RELEASE_CNT   = 3'd4
  } cfg_idx_t;

  typedef logic [1:0] combo_t;
  localparam combo_t COMBO_NONE = 2'b00;
  localparam combo_t COMBO_STEP = 2'b01;
  localparam combo_t COMBO_MODE = 2'b10;
  localparam combo_t COMBO_BOTH = 2'b11;

  localparam logic [CodeW-1:0] CODE_NONE = 3'b000;
  localparam logic [CodeW-1:0] CODE_STEP = 3'b001;
  localparam logic [CodeW-1:0] CODE_MODE = 3'b010;
  localparam logic [CodeW-1:0] CODE_BOTH = 3'b100;

  typedef struct packed {
    logic [CfgW-1:0] read_period_ms;
    logic [CfgW-1:0] first_long_delay;
    logic [CfgW-1:0] long_repeat_interval;
    logic [CfgW-1:0] one_time_long_seconds;
    logic [CfgW-1:0] release_confirm_count;
  } cfg_t;

  typedef struct packed {
    logic             event_valid;
    logic             long_evt;
    logic [CodeW-1:0] button_code;
    logic [SecsW-1:0] held_seconds;
    logic             one_time_long;
  } res_t;

  function automatic logic [CodeW-1:0] combo_to_code(input combo_t combo);
    logic [CodeW-1:0] code;
    case (combo)
      COMBO_STEP: code = CODE_STEP;
      COMBO_MODE: code = CODE_MODE;
      COMBO_BOTH: code = CODE_BOTH;
      default:    code = CODE_NONE;
    endcase
    return code;
  endfunction

endpackage

// File: hdl/bpc_cfg_regs.sv
// Button press classifier configuration registers.
// Depends on bpc_pkg (cfg_t, register indexes, reset values).
module bpc_cfg_regs import bpc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [CfgW-1:0]    wr_data,
  output cfg_t               cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.read_period_ms        <= READ_PERIOD_RST;
      cfg_r.first_long_delay      <= FIRST_LONG_RST;
      cfg_r.long_repeat_interval  <= LONG_REPEAT_RST;
      cfg_r.one_time_long_seconds <= ONE_TIME_SECS_RST;
      cfg_r.release_confirm_count <= RELEASE_CNT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_READ_PERIOD:   cfg_r.read_period_ms        <= wr_data;
        CFG_FIRST_LONG:    cfg_r.first_long_delay      <= wr_data;
        CFG_LONG_REPEAT:   cfg_r.long_repeat_interval  <= wr_data;
        CFG_ONE_TIME_SECS: cfg_r.one_time_long_seconds <= wr_data;
        CFG_RELEASE_CNT:   cfg_r.release_confirm_count <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/bpc_core.sv
// Button press classifier state and per-sample classification logic.
// Depends on bpc_pkg (cfg_t, res_t, combo codes, combo_to_code).
module bpc_core import bpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic step_en,
  input  logic mode_level,
  input  logic step_level,
  input  logic consumer_ready,
  input  cfg_t cfg,
  output res_t res
);

  combo_t             latched_r, latched_nxt;
  logic               released_r, released_nxt;
  logic               short_r, short_nxt;
  logic [MillisW-1:0] millis_r, millis_nxt;
  logic [SecsW-1:0]   secs_r, secs_nxt;
  logic [CfgW-1:0]    idle_r, idle_nxt;
  logic               flag_r, flag_nxt;
  logic [CfgW-1:0]    cd_r, cd_nxt;

  combo_t             combo;
  logic [MillisW-1:0] millis_sum;
  logic               millis_wrap;
  logic [SecsW-1:0]   secs_inc;
  logic [SecsW-1:0]   secs_adj;
  logic               flag_adj;
  logic [CfgW-1:0]    cd_dec;
  logic [CfgW-1:0]    idle_inc;
  res_t               ev;

  assign combo       = ~{mode_level, step_level};
  assign millis_sum  = millis_r + MillisW'(cfg.read_period_ms);
  assign millis_wrap = (millis_sum >= MS_PER_SEC);
  assign secs_inc    = millis_wrap ? secs_r + 8'd1 : secs_r;
  assign secs_adj    = flag_r ? '0 : secs_inc;
  assign flag_adj    = flag_r | (secs_adj >= cfg.one_time_long_seconds);
  assign cd_dec      = cd_r - 8'd1;
  assign idle_inc    = idle_r + 8'd1;

  always_comb begin
    latched_nxt  = latched_r;
    released_nxt = released_r;
    short_nxt    = short_r;
    millis_nxt   = millis_r;
    secs_nxt     = secs_r;
    idle_nxt     = idle_r;
    flag_nxt     = flag_r;
    cd_nxt       = cd_r;
    ev           = '0;
    if (combo != COMBO_NONE) begin
      idle_nxt = '0;
      if (released_r || combo != latched_r) begin
        latched_nxt = combo;
        short_nxt   = 1'b0;
        millis_nxt  = '0;
        secs_nxt    = '0;
        flag_nxt    = 1'b0;
      end else begin
        millis_nxt = millis_wrap ? millis_sum - MS_PER_SEC : millis_sum;
        secs_nxt   = secs_inc;
        if (!short_r) begin
          ev.event_valid   = 1'b1;
          ev.long_evt      = 1'b0;
          ev.button_code   = combo_to_code(combo);
          ev.held_seconds  = secs_inc;
          ev.one_time_long = flag_r;
          short_nxt        = 1'b1;
          cd_nxt           = cfg.first_long_delay;
        end else if (cd_r != '0) begin
          cd_nxt = cd_dec;
          if (cd_dec == '0) begin
            secs_nxt         = secs_adj;
            flag_nxt         = flag_adj;
            ev.event_valid   = 1'b1;
            ev.long_evt      = 1'b1;
            ev.button_code   = combo_to_code(combo);
            ev.held_seconds  = secs_adj;
            ev.one_time_long = flag_adj;
            cd_nxt           = cfg.long_repeat_interval;
          end
        end
      end
      released_nxt = 1'b0;
    end else begin
      idle_nxt = idle_inc;
      if (idle_inc >= cfg.release_confirm_count || !short_r) begin
        released_nxt = 1'b1;
        latched_nxt  = COMBO_NONE;
        idle_nxt     = '0;
        short_nxt    = 1'b0;
        millis_nxt   = '0;
        secs_nxt     = '0;
        flag_nxt     = 1'b0;
      end
    end
  end

  // events are dropped, not held, when the consumer is busy
  assign res = consumer_ready ? ev : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r  <= COMBO_NONE;
      released_r <= 1'b1;
      short_r    <= 1'b0;
      millis_r   <= '0;
      secs_r     <= '0;
      idle_r     <= '0;
      flag_r     <= 1'b0;
      cd_r       <= FIRST_LONG_RST;
    end else if (step_en) begin
      latched_r  <= latched_nxt;
      released_r <= released_nxt;
      short_r    <= short_nxt;
      millis_r   <= millis_nxt;
      secs_r     <= secs_nxt;
      idle_r     <= idle_nxt;
      flag_r     <= flag_nxt;
      cd_r       <= cd_nxt;
    end
  end

endmodule

// File: hdl/button_press_classifier.sv
// Button press classifier top level: input register, classification core,
// result register and configuration registers.
// Depends on bpc_pkg, bpc_cfg_regs and bpc_core.
//
// Takes one button sample per item and returns exactly one result item per
// sample. One item per cycle is sustained; each item passes through the input
// register and then the result register before its result is on the output,
// and the only thing that slows the block is out_stall holding the result
// register. Configuration writes are always ready and take effect on the
// next item.
module button_press_classifier import bpc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode_level,
  input  logic               in_step_level,
  input  logic               in_consumer_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_event_valid,
  output logic               out_long_evt,
  output logic [CodeW-1:0]   out_button_code,
  output logic [SecsW-1:0]   out_held_seconds,
  output logic               out_one_time_long,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  logic in_vld_r, in_vld_nxt;
  logic in_mode_r, in_step_r, in_ready_r;
  logic out_vld_r, out_vld_nxt;
  res_t out_res_r;
  res_t res;
  cfg_t cfg;
  logic advance;
  logic accept;

  assign cfg_ready = 1'b1;

  bpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign accept   = in_valid && !in_stall;

  bpc_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (advance),
    .mode_level     (in_mode_r),
    .step_level     (in_step_r),
    .consumer_ready (in_ready_r),
    .cfg            (cfg),
    .res            (res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_mode_r  <= in_mode_level;
      in_step_r  <= in_step_level;
      in_ready_r <= in_consumer_ready;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_event_valid   = out_res_r.event_valid;
  assign out_long_evt      = out_res_r.long_evt;
  assign out_button_code   = out_res_r.button_code;
  assign out_held_seconds  = out_res_r.held_seconds;
  assign out_one_time_long = out_res_r.one_time_long;

endmodule

// File: hdl/bpc_checker.sv
// Button press classifier port checker and its bind to the top level.
// Depends on bpc_pkg and button_press_classifier.
module bpc_checker import bpc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_event_valid,
  input logic               out_long_evt,
  input logic [CodeW-1:0]   out_button_code,
  input logic [SecsW-1:0]   out_held_seconds,
  input logic               out_one_time_long
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present right after reset");

  a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_event_valid |->
      !out_long_evt && out_button_code == CODE_NONE &&
      out_held_seconds == '0 && !out_one_time_long)
    else $error("empty item carries nonzero fields");

  a_code_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_valid |-> $onehot(out_button_code))
    else $error("event code not one-hot");

  // a short press always follows a fresh latch, so nothing has accumulated
  a_short_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_valid && !out_long_evt |->
      !out_one_time_long && out_held_seconds == '0)
    else $error("short press with accumulated hold");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_valid) &&
      $stable(out_long_evt) && $stable(out_button_code) &&
      $stable(out_held_seconds) && $stable(out_one_time_long))
    else $error("stalled item changed");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);

// File: tb/bpc_checker.sv
// Checker for the button press classifier: watches the sample, result and
// register channels, predicts each result and compares it field by field.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
module bpc_tb_checker import bpc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_mode_level,
  input  logic               in_step_level,
  input  logic               in_consumer_ready,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_event_valid,
  input  logic               out_long_evt,
  input  logic [CodeW-1:0]   out_button_code,
  input  logic [SecsW-1:0]   out_held_seconds,
  input  logic               out_one_time_long,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  output int                 fail_count,
  output int                 pending
);

  cfg_t              regs;
  combo_t            latched;
  logic              released;
  logic              short_done;
  logic [MillisW-1:0] millis;
  logic [SecsW-1:0]  secs;
  logic [7:0]        idle_cnt;
  logic              one_time;
  logic [7:0]        countdown;
  res_t              expected_events[$];

  function automatic void clear_hold();
    short_done = 1'b0;
    millis     = '0;
    secs       = '0;
    one_time   = 1'b0;
  endfunction

  function automatic void reset_state();
    regs = '{read_period_ms:        READ_PERIOD_RST,
             first_long_delay:      FIRST_LONG_RST,
             long_repeat_interval:  LONG_REPEAT_RST,
             one_time_long_seconds: ONE_TIME_SECS_RST,
             release_confirm_count: RELEASE_CNT_RST};
    latched   = COMBO_NONE;
    released  = 1'b1;
    idle_cnt  = '0;
    clear_hold();
    countdown = FIRST_LONG_RST;
  endfunction

  function automatic res_t make_event(input combo_t c, input logic is_long);
    res_t r;
    r.event_valid   = 1'b1;
    r.long_evt      = is_long;
    r.button_code   = CodeW'(1) << (c - 2'd1);
    r.held_seconds  = secs;
    r.one_time_long = one_time;
    return r;
  endfunction

  function automatic res_t classify_sample(input logic mode, input logic step,
                                           input logic ready);
    res_t   r;
    combo_t c;
    r = '0;
    c = ~{mode, step};
    if (c != COMBO_NONE) begin
      idle_cnt = '0;
      if (released || c != latched) begin
        latched = c;
        clear_hold();
      end else begin
        millis = millis + MillisW'(regs.read_period_ms);
        if (millis >= MS_PER_SEC) begin
          millis = millis - MS_PER_SEC;
          secs   = secs + 1'b1;
        end
        if (!short_done) begin
          if (ready) r = make_event(c, 1'b0);
          short_done = 1'b1;
          countdown  = regs.first_long_delay;
        end else if (countdown != 0) begin
          countdown = countdown - 1'b1;
          if (countdown == 0) begin
            if (one_time) secs = '0;
            if (secs >= regs.one_time_long_seconds) one_time = 1'b1;
            if (ready) r = make_event(c, 1'b1);
            countdown = regs.long_repeat_interval;
          end
        end
      end
      released = 1'b0;
    end else begin
      idle_cnt = idle_cnt + 1'b1;
      if (idle_cnt >= regs.release_confirm_count || !short_done) begin
        released = 1'b1;
        latched  = COMBO_NONE;
        idle_cnt = '0;
        clear_hold();
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      reset_state();
      expected_events.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $error("result item with no sample pending");
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_valid", 8'(want.event_valid), 8'(out_event_valid));
          check_field("long_evt", 8'(want.long_evt), 8'(out_long_evt));
          check_field("button_code", 8'(want.button_code), 8'(out_button_code));
          check_field("held_seconds", want.held_seconds, out_held_seconds);
          check_field("one_time_long", 8'(want.one_time_long), 8'(out_one_time_long));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_READ_PERIOD:   regs.read_period_ms        = cfg_data;
          CFG_FIRST_LONG:    regs.first_long_delay      = cfg_data;
          CFG_LONG_REPEAT:   regs.long_repeat_interval  = cfg_data;
          CFG_ONE_TIME_SECS: regs.one_time_long_seconds = cfg_data;
          CFG_RELEASE_CNT:   regs.release_confirm_count = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_events.push_back(classify_sample(in_mode_level, in_step_level,
                                                  in_consumer_ready));
    end
    pending = expected_events.size();
  end

endmodule

// File: tb/tb_top.sv
// Testbench top for the button press classifier: clock, reset, sample and
// register stimulus, output stall pattern and the final verdict.
// Depends on bpc_pkg, button_press_classifier and bpc_tb_checker.
`timescale 1ns / 1ps
module tb_top;
  import bpc_pkg::*;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;
  localparam int HOLD_OFF_CYCLES = 300;

  // {mode, step, consumer_ready} per item
  localparam logic [59:0] DIRECTED = {
    3'b111, 3'b101, 3'b101, 3'b101, 3'b111, 3'b111, 3'b111, 3'b011, 3'b010, 3'b001,
    3'b001, 3'b101, 3'b111, 3'b101, 3'b101, 3'b110, 3'b101, 3'b111, 3'b111, 3'b111};

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_mode_level;
  logic               in_step_level;
  logic               in_consumer_ready;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_event_valid;
  logic               out_long_evt;
  logic [CodeW-1:0]   out_button_code;
  logic [SecsW-1:0]   out_held_seconds;
  logic               out_one_time_long;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;

  int         fail_count;
  int         pending;
  int         idle_mode = IDLE_NONE;
  int         hold_req = 0;
  int         hold_served = 0;
  int         hold_left = 0;
  int         samples_sent = 0;
  logic [7:0] cur_first;
  logic [7:0] cur_repeat;
  logic [7:0] cur_release;

  button_press_classifier dut (.*);

  bpc_tb_checker u_checker (.*);

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (hold_req != hold_served) begin
      hold_served = hold_req;
      hold_left   = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (idle_mode == IDLE_RECV) begin
      out_stall = $urandom_range(0, 99) < 49;
    end else if (idle_mode == IDLE_BOTH) begin
      out_stall = $urandom_range(0, 99) < 8;
    end else begin
      out_stall = 1'b0;
    end
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_sample(input logic mode, input logic step, input logic ready);
    int pct;
    pct = (idle_mode == IDLE_SEND) ? 49 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    @(negedge clk);
    while ($urandom_range(0, 99) < pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_mode_level     = mode;
    in_step_level     = step;
    in_consumer_ready = ready;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  task automatic send_combo(input combo_t c, input int n);
    repeat (n) send_sample(~c[1], ~c[0], $urandom_range(0, 3) != 0);
  endtask

  task automatic idle_run(input int n);
    repeat (n) send_sample(1'b1, 1'b1, 1'($urandom_range(0, 1)));
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] period, input logic [7:0] first,
                              input logic [7:0] rpt, input logic [7:0] secs,
                              input logic [7:0] rel);
    write_reg(CFG_READ_PERIOD, period);
    write_reg(CFG_FIRST_LONG, first);
    write_reg(CFG_LONG_REPEAT, rpt);
    write_reg(CFG_ONE_TIME_SECS, secs);
    write_reg(CFG_RELEASE_CNT, rel);
    @(negedge clk);
    cfg_valid   = 1'b0;
    cur_first   = first;
    cur_repeat  = rpt;
    cur_release = rel;
  endtask

  // drain: wait until every predicted result has come out
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] pick8(input logic [7:0] lo, input logic [7:0] hi,
                                       input int rlo, input int rhi);
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return hi;
      default: return 8'($urandom_range(rlo, rhi));
    endcase
  endfunction

  initial begin
    int     k;
    int     ph;
    int     target;
    int     hi;
    bit     paused;
    combo_t c;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_mode_level     = 1'b1;
    in_step_level     = 1'b1;
    in_consumer_ready = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = CFG_READ_PERIOD;
    cfg_data          = '0;
    cur_first         = FIRST_LONG_RST;
    cur_repeat        = LONG_REPEAT_RST;
    cur_release       = RELEASE_CNT_RST;
    paused            = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    for (k = 0; k < 20; k++)
      send_sample(DIRECTED[59-3*k], DIRECTED[58-3*k], DIRECTED[57-3*k]);
    wait_idle();

    // no long events: seconds count runs past 255 and wraps
    write_config(8'd255, 8'd0, 8'd0, 8'd255, 8'd255);
    send_combo(COMBO_STEP, 1010);
    idle_run(4);
    wait_idle();

    // zero release count, zero threshold, fastest long repeat
    write_config(8'd1, 8'd1, 8'd1, 8'd0, 8'd0);
    send_combo(COMBO_MODE, 6);
    idle_run(1);
    send_combo(COMBO_BOTH, 6);
    idle_run(2);
    wait_idle();

    for (ph = 0; ph < 8; ph++) begin
      write_config(pick8(8'd1, 8'd255, 1, 255), pick8(8'd0, 8'd255, 0, 12),
                   pick8(8'd0, 8'd255, 0, 8), pick8(8'd0, 8'd255, 0, 12),
                   pick8(8'd1, 8'd255, 1, 6));
      idle_mode = ph % 4;
      target    = samples_sent + 12;
      if (ph == 2) hold_req++;
      while (samples_sent < target) begin
        c = combo_t'($urandom_range(1, 3));
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: begin
            hi = 3 + cur_first + 3 * cur_repeat;
            if (hi > 60) hi = 60;
            send_combo(c, $urandom_range(1, hi));
            if ($urandom_range(0, 1) && cur_release < 8) idle_run(cur_release + 1);
            else idle_run($urandom_range(1, 4));
          end
          7: begin
            send_combo(c, $urandom_range(1, 6));
            if ($urandom_range(0, 1)) idle_run($urandom_range(1, 2));
            send_combo(combo_t'($urandom_range(1, 3)), $urandom_range(1, 10));
          end
          default: begin
            repeat ($urandom_range(1, 8))
              send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
          end
        endcase
        if (ph == 5 && !paused) begin
          paused = 1'b1;
          wait_idle();
        end
      end
      wait_idle();
      idle_mode = IDLE_NONE;
    end

    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
